// ===== hw/rtl/ltee_pkg.sv =====
package ltee_pkg;

	localparam int unsigned NUM_LEDS_DEF = 64;
	localparam int unsigned LED_W        = 6;
	localparam int unsigned BRIGHT_W     = 6;
	localparam int unsigned COLOUR_W     = 8;
	localparam int unsigned CNT_W        = 7;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 8;
	localparam int unsigned STEP_W       = 6;

	localparam logic [BRIGHT_W-1:0] PEAK_LEVEL  = 6'd50;
	localparam logic [BRIGHT_W-1:0] FLOOR_LEVEL = 6'd10;

	localparam logic [CNT_W-1:0]    MAX_ACTIVE_RST = 7'd20;
	localparam logic [STEP_W-1:0]   RISE_STEP_RST  = 6'd2;
	localparam logic [STEP_W-1:0]   FALL_STEP_RST  = 6'd1;
	localparam logic [COLOUR_W-1:0] IDLE_RED_RST   = 8'd10;
	localparam logic [COLOUR_W-1:0] IDLE_GREEN_RST = 8'd0;
	localparam logic [COLOUR_W-1:0] IDLE_BLUE_RST  = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ACTIVE = 3'd0,
		REG_RISE_STEP  = 3'd1,
		REG_FALL_STEP  = 3'd2,
		REG_IDLE_RED   = 3'd3,
		REG_IDLE_GREEN = 3'd4,
		REG_IDLE_BLUE  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_RISE  = 2'd1,
		PH_FALL  = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	typedef enum logic {
		SQ_IDLE = 1'b0,
		SQ_RUN  = 1'b1
	} seq_state_t;

	typedef struct packed {
		logic                idle;
		phase_t              phase;
		logic [BRIGHT_W-1:0] bright;
	} led_entry_t;

	localparam led_entry_t ENTRY_RST = '{idle: 1'b1, phase: PH_START, bright: '0};

	// Brightness never exceeds 63, where (b * 13) >> 7 equals b / 10 exactly.
	function automatic logic [COLOUR_W-1:0] bright_div10(input logic [BRIGHT_W-1:0] b);
		logic [9:0] prod;
		prod = 10'(b) * 10'd13;
		return COLOUR_W'(prod[9:7]);
	endfunction

endpackage

// ===== hw/rtl/led_twinkle_envelope_engine_top.sv =====
// Twinkle envelope engine. Each accepted request is one frame tick carrying a candidate LED;
// the block then walks LEDs 0 to NUM_LEDS-1, one LED per cycle unless the output is stalled,
// through a single shared envelope step unit, and emits one colour per LED with last marking
// the final one. Each LED goes through the read index, the memory read register and the
// output register in turn; the sequencer returns to idle as the last colour is registered,
// so the next request can be taken while that colour is on the output. in_stall is high
// for the whole walk. LED state lives in a small memory with one read and one write a cycle;
// per-entry valid bits make it read as free after reset, so no clearing pass is needed.
// Configuration must be written only between ticks by the user; the block does not enforce this.
module led_twinkle_envelope_engine_top
	import ltee_pkg::*;
#(
	parameter int unsigned NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [LED_W-1:0]      candidate_led,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LED_W-1:0]      led_index,
	output logic [COLOUR_W-1:0]   red,
	output logic [COLOUR_W-1:0]   green,
	output logic [COLOUR_W-1:0]   blue,
	output logic                  last
);

	localparam int unsigned IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

	logic [CNT_W-1:0]    max_active_q;
	logic [STEP_W-1:0]   rise_step_q;
	logic [STEP_W-1:0]   fall_step_q;
	logic [COLOUR_W-1:0] idle_red_q;
	logic [COLOUR_W-1:0] idle_green_q;
	logic [COLOUR_W-1:0] idle_blue_q;

	seq_state_t state_q, state_d;
	logic              in_take;
	logic              take_q;
	logic [LED_W-1:0]  cand_q;
	logic [CNT_W-1:0]  act_cnt_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_pend_q;
	logic              rd_en;
	logic              s1_valid_q;
	logic [IDX_W-1:0]  idx_s1;
	led_entry_t        rdata_s1;
	logic              vld_s1;
	logic              adv;
	logic              proc;

	led_entry_t        mem_q [NUM_LEDS];
	logic [NUM_LEDS-1:0] vld_q;

	led_entry_t        cur;
	led_entry_t        nxt;
	led_entry_t        stepped;
	logic              spawn;
	logic              freeing;
	logic [CNT_W-1:0]  cnt_d;
	logic [BRIGHT_W:0] rise_sum;
	logic [BRIGHT_W:0] fall_lim;

	logic                out_valid_q;
	logic [LED_W-1:0]    led_index_q;
	logic [COLOUR_W-1:0] red_q;
	logic [COLOUR_W-1:0] green_q;
	logic [COLOUR_W-1:0] blue_q;
	logic                last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= MAX_ACTIVE_RST;
			rise_step_q  <= RISE_STEP_RST;
			fall_step_q  <= FALL_STEP_RST;
			idle_red_q   <= IDLE_RED_RST;
			idle_green_q <= IDLE_GREEN_RST;
			idle_blue_q  <= IDLE_BLUE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_ACTIVE: max_active_q <= cfg_data[CNT_W-1:0];
				REG_RISE_STEP:  rise_step_q  <= cfg_data[STEP_W-1:0];
				REG_FALL_STEP:  fall_step_q  <= cfg_data[STEP_W-1:0];
				REG_IDLE_RED:   idle_red_q   <= cfg_data;
				REG_IDLE_GREEN: idle_green_q <= cfg_data;
				REG_IDLE_BLUE:  idle_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: if (in_valid) state_d = SQ_RUN;
			SQ_RUN:  if (proc && idx_s1 == LAST_IDX) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != SQ_IDLE);
		in_take  = in_valid && (state_q == SQ_IDLE);
		adv      = !out_valid_q || !out_stall;
		proc     = s1_valid_q && adv;
		rd_en    = rd_pend_q && (!s1_valid_q || adv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_IDLE;
			take_q     <= 1'b0;
			cand_q     <= '0;
			rd_idx_q   <= '0;
			rd_pend_q  <= 1'b0;
			s1_valid_q <= 1'b0;
			idx_s1     <= '0;
			act_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				// The star limit is judged once, on the count at the start of the tick.
				take_q    <= (act_cnt_q < max_active_q) &&
				             ({1'b0, candidate_led} < (LED_W + 1)'(NUM_LEDS));
				cand_q    <= candidate_led;
				rd_idx_q  <= '0;
				rd_pend_q <= 1'b1;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					rd_pend_q <= 1'b0;
				end
			end
			if (rd_en) begin
				s1_valid_q <= 1'b1;
				idx_s1     <= rd_idx_q;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (proc) begin
				act_cnt_q <= cnt_d;
			end
		end
	end

	// LED state memory, one read and one write a cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_idx_q];
		end
		if (proc) begin
			mem_q[idx_s1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= vld_q[rd_idx_q];
			end
			if (proc) begin
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Shared envelope step unit.
	always_comb begin
		cur      = vld_s1 ? rdata_s1 : ENTRY_RST;
		spawn    = take_q && (cand_q == LED_W'(idx_s1)) && cur.idle;
		freeing  = !cur.idle && !spawn && (cur.phase == PH_END);
		rise_sum = {1'b0, cur.bright} + {1'b0, rise_step_q};
		fall_lim = {1'b0, FLOOR_LEVEL} + {1'b0, fall_step_q};
		stepped  = cur;
		case (cur.phase)
			PH_START: begin
				stepped.bright = FLOOR_LEVEL;
				stepped.phase  = PH_RISE;
			end
			PH_RISE: begin
				if (rise_sum >= {1'b0, PEAK_LEVEL}) begin
					stepped.bright = PEAK_LEVEL;
					stepped.phase  = PH_FALL;
				end else begin
					stepped.bright = rise_sum[BRIGHT_W-1:0];
				end
			end
			PH_FALL: begin
				// Same as a signed test of brightness minus step against the floor.
				if ({1'b0, cur.bright} <= fall_lim) begin
					stepped.bright = FLOOR_LEVEL;
					stepped.phase  = PH_END;
				end else begin
					stepped.bright = cur.bright - fall_step_q;
				end
			end
			default: begin
				stepped.bright = '0;
				stepped.phase  = PH_START;
			end
		endcase

		nxt   = cur;
		cnt_d = act_cnt_q;
		if (spawn) begin
			nxt      = stepped;
			nxt.idle = 1'b0;
			cnt_d    = act_cnt_q + 1'b1;
		end else if (!cur.idle) begin
			nxt      = stepped;
			nxt.idle = freeing;
			if (freeing) begin
				cnt_d = act_cnt_q - 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			led_index_q <= LED_W'(idx_s1);
			last_q      <= (idx_s1 == LAST_IDX);
			if (nxt.idle) begin
				red_q   <= idle_red_q;
				green_q <= idle_green_q;
				blue_q  <= idle_blue_q;
			end else begin
				red_q   <= COLOUR_W'(nxt.bright);
				green_q <= '0;
				blue_q  <= bright_div10(nxt.bright);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign led_index = led_index_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign last      = last_q;

	a_stall_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q || rd_pend_q) |-> in_stall)
		else $error("input taken while a tick is still being walked");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		act_cnt_q <= CNT_W'(NUM_LEDS))
		else $error("active star count above the number of LEDs");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (led_index == LED_W'(NUM_LEDS - 1)))
		else $error("last flag on an LED other than the final one");

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == SQ_RUN && rd_pend_q))
		else $error("accepted request did not start a walk");

	a_spawn_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && spawn) |-> (take_q && cur.idle))
		else $error("star spawned on a busy LED or without a take");

endmodule
